// ===== hdl/b128e_pkg.sv =====
`timescale 1ns / 1ps

package b128e_pkg;

    localparam int GROUP_LEN = 7;
    localparam int SYM_W     = 7;

    localparam logic [2:0] LAST_FILL = 3'd6;
    localparam logic [2:0] LAST_SYM  = 3'd7;

    // escape codes for the unsafe symbols
    localparam logic [3:0] ESC_NUL   = 4'd0;
    localparam logic [3:0] ESC_CR    = 4'd1;
    localparam logic [3:0] ESC_LF    = 4'd2;
    localparam logic [3:0] ESC_DQUOT = 4'd3;
    localparam logic [3:0] ESC_QUOT  = 4'd4;
    localparam logic [3:0] ESC_BTICK = 4'd5;
    localparam logic [3:0] ESC_DOLL  = 4'd6;
    localparam logic [3:0] ESC_BSL   = 4'd7;
    localparam logic [3:0] ESC_AMP   = 4'd8;
    localparam logic [3:0] ESC_GT    = 4'd9;
    localparam logic [3:0] ESC_LT    = 4'd10;

    localparam logic [1:0] LEAD_TAG  = 2'b11;
    localparam logic [1:0] TRAIL_TAG = 2'b10;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       message_done;
    } t_out_beat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_GROUP,
        ST_TRAIL,
        ST_FLUSH,
        ST_FINISH
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic       accept;     // take input beat into the group
        logic       pad;        // pad the open group
        logic       push_sym;   // run one symbol through the hold stage
        logic       push_trail; // second byte of an escape pair
        logic       clear_fill; // group fully encoded
        logic       flush;      // send held symbol as plain byte
        logic       finish;     // release pending byte as last of the run
        logic       eom;        // run ends the message
        logic [2:0] sym_idx;    // symbol slot within the group
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] fill;
        logic       held_vld;
        logic       held_unsafe;
        logic       pend_vld;
        logic       can_out;
    } t_dp_sts;

    typedef struct packed {
        logic       unsafe;
        logic [3:0] code;
    } t_esc;

    function automatic t_esc esc_lookup(input logic [SYM_W-1:0] sym);
        t_esc r;
        r.unsafe = 1'b1;
        r.code   = ESC_NUL;
        unique case (sym)
            7'h00:   r.code = ESC_NUL;
            7'h0D:   r.code = ESC_CR;
            7'h0A:   r.code = ESC_LF;
            7'h22:   r.code = ESC_DQUOT;
            7'h27:   r.code = ESC_QUOT;
            7'h60:   r.code = ESC_BTICK;
            7'h24:   r.code = ESC_DOLL;
            7'h5C:   r.code = ESC_BSL;
            7'h26:   r.code = ESC_AMP;
            7'h3E:   r.code = ESC_GT;
            7'h3C:   r.code = ESC_LT;
            default: r.unsafe = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/base128_escaping_encoder.sv =====
// A beat that completes no group and ends no message is taken without output.
// A completed group runs eight symbols, plus a trail byte per escape pair, then a finish step;
// a message end adds a pad step, the pad group's symbols and a flush step before the finish.
// Input waits while a group is encoded. The hold stage moves one symbol per cycle when the
// output is not stalled, ahead of the single output register. Reset: synchronous, active
// low; clears the group fill, the hold stage and the output register.
`timescale 1ns / 1ps

module base128_escaping_encoder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  b128e_pkg::t_in_beat  i_in_beat,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output b128e_pkg::t_out_beat o_out_beat
);
    import b128e_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencing
    b128e_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_beat  (i_in_beat),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // group store, hold stage and output beat
    b128e_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_beat   (i_in_beat),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );

endmodule

// ===== hdl/b128e_ctrl.sv =====
`timescale 1ns / 1ps

module b128e_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  b128e_pkg::t_in_beat i_in_beat,
    output logic               o_in_ready,
    input  b128e_pkg::t_dp_sts i_sts,
    output b128e_pkg::t_dp_cmd o_cmd
);
    import b128e_pkg::*;

    t_state     r_state, n_state;
    logic [2:0] r_sym_idx, n_sym_idx;
    logic       r_eom, n_eom;
    logic       r_padded, n_padded;

    logic       last_sym;
    t_state     after_group;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_sym_idx <= '0;
            r_eom     <= 1'b0;
            r_padded  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sym_idx <= n_sym_idx;
            r_eom     <= n_eom;
            r_padded  <= n_padded;
        end
    end

    // where to go once the eighth symbol is consumed
    assign last_sym = (r_sym_idx == LAST_SYM);
    always_comb begin
        if (r_padded) begin
            after_group = ST_FLUSH;
        end else if (r_eom) begin
            after_group = ST_PAD;
        end else begin
            after_group = ST_FINISH;
        end
    end

    // next state and commands
    always_comb begin
        n_state       = r_state;
        n_sym_idx     = r_sym_idx;
        n_eom         = r_eom;
        n_padded      = r_padded;
        o_cmd         = '0;
        o_cmd.sym_idx = r_sym_idx;
        o_cmd.eom     = r_eom;
        o_in_ready    = (r_state == ST_IDLE);

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_eom        = i_in_beat.end_of_message;
                    n_padded     = 1'b0;
                    n_sym_idx    = '0;
                    if (i_in_beat.byte_valid && i_sts.fill == LAST_FILL) begin
                        n_state = ST_GROUP;
                    end else if (i_in_beat.end_of_message) begin
                        n_state = ST_PAD;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_PAD: begin
                o_cmd.pad = 1'b1;
                n_padded  = 1'b1;
                n_sym_idx = '0;
                n_state   = ST_GROUP;
            end
            ST_GROUP: begin
                if (!i_sts.held_vld || i_sts.can_out) begin
                    o_cmd.push_sym = 1'b1;
                    if (i_sts.held_vld && i_sts.held_unsafe) begin
                        n_state = ST_TRAIL;
                    end else if (last_sym) begin
                        o_cmd.clear_fill = 1'b1;
                        n_sym_idx        = '0;
                        n_state          = after_group;
                    end else begin
                        n_sym_idx = r_sym_idx + 3'd1;
                    end
                end
            end
            ST_TRAIL: begin
                if (i_sts.can_out) begin
                    o_cmd.push_trail = 1'b1;
                    if (last_sym) begin
                        o_cmd.clear_fill = 1'b1;
                        n_sym_idx        = '0;
                        n_state          = after_group;
                    end else begin
                        n_sym_idx = r_sym_idx + 3'd1;
                        n_state   = ST_GROUP;
                    end
                end
            end
            ST_FLUSH: begin
                if (!i_sts.held_vld) begin
                    n_state = ST_FINISH;
                end else if (i_sts.can_out) begin
                    o_cmd.flush = 1'b1;
                    n_state     = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!i_sts.pend_vld || i_sts.can_out) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/b128e_dp.sv =====
`timescale 1ns / 1ps

module b128e_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  b128e_pkg::t_in_beat  i_in_beat,
    input  b128e_pkg::t_dp_cmd   i_cmd,
    output b128e_pkg::t_dp_sts   o_sts,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output b128e_pkg::t_out_beat o_out_beat
);
    import b128e_pkg::*;

    logic [7:0]       r_store [GROUP_LEN];
    logic [2:0]       r_fill;
    logic [SYM_W-1:0] r_held;
    logic             r_held_vld;
    logic [7:0]       r_pend;
    logic             r_pend_vld;
    t_out_beat        r_out;
    logic             r_out_vld;

    logic [55:0]      cat;
    logic [SYM_W-1:0] sym;
    t_esc             held_esc;
    logic [2:0]       pad_cnt;
    logic             emit_en;
    logic [7:0]       emit_byte;
    logic             can_out;
    logic             out_load;

    // symbol select, MSB first over the 56-bit group
    assign cat = {r_store[0], r_store[1], r_store[2], r_store[3],
                  r_store[4], r_store[5], r_store[6]};
    always_comb begin
        unique case (i_cmd.sym_idx)
            3'd0: sym = cat[55:49];
            3'd1: sym = cat[48:42];
            3'd2: sym = cat[41:35];
            3'd3: sym = cat[34:28];
            3'd4: sym = cat[27:21];
            3'd5: sym = cat[20:14];
            3'd6: sym = cat[13:7];
            3'd7: sym = cat[6:0];
            default: sym = cat[6:0];
        endcase
    end

    assign held_esc = esc_lookup(r_held);
    assign pad_cnt  = 3'd7 - r_fill;
    assign can_out  = !r_out_vld || i_out_ready;

    // byte produced this cycle, if any
    always_comb begin
        emit_en   = 1'b0;
        emit_byte = {1'b0, r_held};
        if (i_cmd.push_sym && r_held_vld) begin
            emit_en = 1'b1;
            if (held_esc.unsafe) begin
                emit_byte = {LEAD_TAG, 1'b0, held_esc.code, sym[6]};
            end
        end else if (i_cmd.push_trail) begin
            emit_en   = 1'b1;
            emit_byte = {TRAIL_TAG, sym[5:0]};
        end else if (i_cmd.flush) begin
            emit_en = 1'b1;
        end
    end

    // output register takes the pending byte on a new emit or at run end
    assign out_load = r_pend_vld && (emit_en || i_cmd.finish);

    // group store: no reset, every entry written before it is read
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_in_beat.byte_valid) begin
            r_store[r_fill] <= i_in_beat.data_byte;
        end else if (i_cmd.pad) begin
            for (int i = 0; i < GROUP_LEN; i++) begin
                if (3'(i) >= r_fill) begin
                    r_store[i] <= {5'd0, pad_cnt};
                end
            end
        end
    end

    // fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.clear_fill) begin
            r_fill <= '0;
        end else if (i_cmd.accept && i_in_beat.byte_valid) begin
            r_fill <= r_fill + 3'd1;
        end
    end

    // hold stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_vld <= 1'b0;
            r_held     <= '0;
        end else if (i_cmd.push_sym) begin
            if (!(r_held_vld && held_esc.unsafe)) begin
                r_held     <= sym;
                r_held_vld <= 1'b1;
            end
        end else if (i_cmd.push_trail || i_cmd.flush) begin
            r_held_vld <= 1'b0;
        end
    end

    // pending byte and output register; pending waits to learn if it ends the run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (emit_en) begin
                if (r_pend_vld) begin
                    r_out <= '{out_byte: r_pend, run_last: 1'b0, message_done: 1'b0};
                end
                r_pend     <= emit_byte;
                r_pend_vld <= 1'b1;
            end else if (i_cmd.finish && r_pend_vld) begin
                r_out      <= '{out_byte: r_pend, run_last: 1'b1,
                                message_done: i_cmd.eom};
                r_pend_vld <= 1'b0;
            end
        end
    end

    assign o_sts.fill        = r_fill;
    assign o_sts.held_vld    = r_held_vld;
    assign o_sts.held_unsafe = held_esc.unsafe;
    assign o_sts.pend_vld    = r_pend_vld;
    assign o_sts.can_out     = can_out;

    assign o_out_valid = r_out_vld;
    assign o_out_beat  = r_out;

endmodule

// ===== verif/tb_base128_escaping_encoder.sv =====
`timescale 1ns / 1ps

module tb_base128_escaping_encoder;

    import b128e_pkg::*;

    localparam int WORK_BEATS  = 450;     // directed plus random beats that do something
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 64;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_beat  in_beat   = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_beat out_beat;

    // stimulus and scoreboard state
    t_in_beat  beat_q [$];
    t_out_beat enc_exp_q [$];
    logic      in_taken  = 1'b0;
    int        total_beats;
    int        sent_cnt  = 0;
    int        work_cnt  = 0;
    int        fault_cnt = 0;
    int        cycle_cnt = 0;
    int        msg_cnt   = 0;
    int        byte_cnt  = 0;
    int        pair_cnt  = 0;
    int        rx_cnt    = 0;

    // encoder shadow state
    logic [7:0] grp_bytes [GROUP_LEN];
    int         grp_fill = 0;
    logic [6:0] hold_sym = '0;
    logic       hold_vld = 1'b0;
    logic [7:0] run_bytes [$];

    base128_escaping_encoder u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (out_beat)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // escape code of an unsafe symbol, -1 when the symbol is safe
    function automatic int escape_code_of(input logic [6:0] s);
        case (s)
            7'h00:   return int'(ESC_NUL);
            7'h0D:   return int'(ESC_CR);
            7'h0A:   return int'(ESC_LF);
            7'h22:   return int'(ESC_DQUOT);
            7'h27:   return int'(ESC_QUOT);
            7'h60:   return int'(ESC_BTICK);
            7'h24:   return int'(ESC_DOLL);
            7'h5C:   return int'(ESC_BSL);
            7'h26:   return int'(ESC_AMP);
            7'h3E:   return int'(ESC_GT);
            7'h3C:   return int'(ESC_LT);
            default: return -1;
        endcase
    endfunction

    // one symbol through the hold stage
    task automatic hold_push(input logic [6:0] s);
        int         code;
        logic [3:0] c4;
        if (hold_vld) begin
            code = escape_code_of(hold_sym);
            if (code >= 0) begin
                c4 = code[3:0];
                run_bytes.push_back({LEAD_TAG, 1'b0, c4, s[6]});
                run_bytes.push_back({TRAIL_TAG, s[5:0]});
                hold_vld = 1'b0;
                pair_cnt++;
                return;
            end
            run_bytes.push_back({1'b0, hold_sym});
        end
        hold_sym = s;
        hold_vld = 1'b1;
    endtask

    // 56 group bits, MSB first, as eight 7-bit symbols
    task automatic encode_group();
        logic [55:0] cat;
        cat = {grp_bytes[0], grp_bytes[1], grp_bytes[2], grp_bytes[3],
               grp_bytes[4], grp_bytes[5], grp_bytes[6]};
        for (int k = 0; k < 8; k++)
            hold_push(cat[55 - 7 * k -: 7]);
    endtask

    // expected output bytes for one accepted input beat
    task automatic predict_beat(input t_in_beat b);
        t_out_beat r;
        run_bytes.delete();
        if (b.byte_valid) begin
            grp_bytes[grp_fill] = b.data_byte;
            grp_fill++;
            byte_cnt++;
            if (grp_fill == GROUP_LEN) begin
                encode_group();
                grp_fill = 0;
            end
        end
        if (b.end_of_message) begin
            for (int i = grp_fill; i < GROUP_LEN; i++)
                grp_bytes[i] = 8'(GROUP_LEN - grp_fill);
            encode_group();
            grp_fill = 0;
            if (hold_vld) begin
                run_bytes.push_back({1'b0, hold_sym});
                hold_vld = 1'b0;
            end
            msg_cnt++;
        end
        foreach (run_bytes[i]) begin
            r.out_byte     = run_bytes[i];
            r.run_last     = (i == run_bytes.size() - 1);
            r.message_done = r.run_last && b.end_of_message;
            enc_exp_q.push_back(r);
        end
    endtask

    task automatic add_beat(input logic [7:0] data, input logic vld, input logic eom);
        t_in_beat b;
        b.data_byte      = data;
        b.byte_valid     = vld;
        b.end_of_message = eom;
        beat_q.push_back(b);
        if (vld || eom)
            work_cnt++;
    endtask

    // a group given as eight symbols, sent as its seven bytes
    task automatic add_sym_group(input logic [55:0] syms, input logic eom_last);
        for (int k = 0; k < GROUP_LEN; k++)
            add_beat(syms[55 - 8 * k -: 8], 1'b1, eom_last && (k == GROUP_LEN - 1));
    endtask

    // driver: presents beats at the falling edge, sets the receiver's ready
    always @(negedge i_clk) begin : drv
        int send_gap_pct;
        int stall_pct;
        if (sent_cnt * 3 < total_beats) begin
            send_gap_pct = 8;
            stall_pct    = 87;
        end else if (sent_cnt * 3 < total_beats * 2) begin
            send_gap_pct = 87;
            stall_pct    = 8;
        end else begin
            send_gap_pct = 0;
            stall_pct    = 0;
        end
        if (i_rst_n) begin
            if (!in_valid || in_taken) begin
                if (beat_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    in_beat  <= beat_q.pop_front();
                    in_valid <= 1'b1;
                    sent_cnt <= sent_cnt + 1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // monitor: predicts on input beats, checks output beats
    always @(posedge i_clk) begin : mon
        t_out_beat want;
        if (i_rst_n) begin
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
                predict_beat(in_beat);
            if (out_valid && out_ready) begin
                rx_cnt++;
                if (enc_exp_q.size() == 0) begin
                    fault_cnt++;
                    $display("%0t: output beat exp none got %h", $realtime, out_beat);
                end else begin
                    want = enc_exp_q.pop_front();
                    if (out_beat.out_byte !== want.out_byte) begin
                        fault_cnt++;
                        $display("%0t: out_byte exp %h got %h", $realtime,
                                 want.out_byte, out_beat.out_byte);
                    end
                    if (out_beat.run_last !== want.run_last) begin
                        fault_cnt++;
                        $display("%0t: run_last exp %b got %b", $realtime,
                                 want.run_last, out_beat.run_last);
                    end
                    if (out_beat.message_done !== want.message_done) begin
                        fault_cnt++;
                        $display("%0t: message_done exp %b got %b", $realtime,
                                 want.message_done, out_beat.message_done);
                    end
                end
            end
        end else begin
            in_taken <= 1'b0;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, enc_exp_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : stim
        int sel;
        int len;
        logic [7:0] d;
        // empty message: a whole group of sevens
        add_beat(8'h5A, 1'b0, 1'b1);
        // idle beat, data ignored
        add_beat(8'hFF, 1'b0, 1'b0);
        // eight unsafe symbols as the lead of a pair
        add_sym_group({7'h00, 7'h0D, 7'h0A, 7'h22, 7'h27, 7'h60, 7'h24, 7'h5C}, 1'b0);
        add_sym_group({7'h0D, 7'h0A, 7'h22, 7'h27, 7'h60, 7'h24, 7'h5C, 7'h26}, 1'b0);
        // last byte with end: full group then pad group, 16 output beats
        add_sym_group({7'h26, 7'h3E, 7'h3E, 7'h3C, 7'h3C, 7'h7F, 7'h00, 7'h7F}, 1'b1);
        // byte extremes, end without byte
        add_beat(8'hFF, 1'b1, 1'b0);
        add_beat(8'h80, 1'b1, 1'b0);
        add_beat(8'h00, 1'b0, 1'b1);

        // random messages, mostly short, some exact multiples of seven
        while (work_cnt < WORK_BEATS) begin
            if ($urandom_range(19) == 0) begin
                add_beat(8'($urandom), 1'b0, 1'b0);
            end else begin
                sel = $urandom_range(99);
                if (sel < 70)
                    len = $urandom_range(13);
                else if (sel < 90)
                    len = 7 * $urandom_range(3);
                else
                    len = $urandom_range(40, 14);
                for (int j = 0; j < len; j++) begin
                    if ($urandom_range(15) == 0)
                        add_beat(8'($urandom), 1'b0, 1'b0);
                    d = ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom);
                    add_beat(d, 1'b1, (j == len - 1) && ($urandom_range(1) == 1)
                                       && (sel < 95));
                end
                // a few messages run on into the next one
                if (sel < 95 && (len == 0 || !beat_q[$].end_of_message))
                    add_beat(8'($urandom), 1'b0, 1'b1);
            end
        end
        total_beats = beat_q.size();

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(negedge i_clk);
        while (beat_q.size() != 0 || in_valid || enc_exp_q.size() != 0);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        $display("%0d input beats (%0d bytes, %0d messages) checked against %0d output beats",
                 total_beats, byte_cnt, msg_cnt, rx_cnt);
        $display("%0d escape pairs, %0d faults", pair_cnt, fault_cnt);
        if (fault_cnt == 0 && enc_exp_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/b128e_pkg.sv
hdl/b128e_ctrl.sv
hdl/b128e_dp.sv
hdl/base128_escaping_encoder.sv
verif/tb_base128_escaping_encoder.sv
